>>> hdl/udet_pkg.sv
// ----------------------------------------------------------------------------
// udet_pkg: shared types, constants and byte classing for the detector
// Holds the byte-order mark bytes, the word type passed between stages and
// the lead byte classification used by the parse stage.
// ----------------------------------------------------------------------------
`default_nettype none

package udet_pkg;

    localparam logic [7:0] MARK_BYTE0 = 8'hEF;
    localparam logic [7:0] MARK_BYTE1 = 8'hBB;
    localparam logic [7:0] MARK_BYTE2 = 8'hBF;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Count of bytes compared against the mark, saturating here
    localparam logic [1:0] MARK_LEN = 2'd3;

    // One input word as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_buffer;
    } word_t;

    // Result of classing a lead byte
    typedef struct packed {
        logic       invalid;
        logic [1:0] cont;
    } lead_class_t;

    // Expected mark byte at a given position
    function automatic logic [7:0] mark_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = MARK_BYTE0;
            2'd1:    b = MARK_BYTE1;
            default: b = MARK_BYTE2;
        endcase
        return b;
    endfunction

    // Class a lead byte by its top bits
    function automatic lead_class_t class_lead(input logic [7:0] b);
        lead_class_t c;
        c.invalid = 1'b0;
        c.cont    = 2'd0;
        priority if (b[7] == 1'b0)
        begin
            c.cont = 2'd0;
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            c.cont = 2'd1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            c.cont = 2'd2;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            c.cont = 2'd3;
        end
        else
        begin
            c.invalid = 1'b1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/utf8_or_gbk_detector.sv
// ----------------------------------------------------------------------------
// utf8_or_gbk_detector: classify a byte buffer as UTF-8 or GBK
// A buffer arrives as a stream of words on the input channel, one byte each,
// with end_of_buffer on the last word; a word with byte_present low and
// end_of_buffer high closes the buffer without a byte (alone, an empty
// buffer, judged UTF-8). A word with both low is dropped.
// One verdict word per buffer leaves on the output channel: bom_found when
// the first three bytes are EF BB BF (which forces UTF-8), is_gbk when the
// UTF-8 parse failed or ended inside a sequence.
// The parse stage takes the closing word from the input register, loads
// the verdict into the result register and raises out_valid. Throughput:
// one word per cycle while no closing word waits on a held verdict; the
// input register and result register are split, so the next buffer streams
// in while a verdict waits. When the receiver stalls, only a closing word
// waits in the input register; other words keep flowing into the parse state.
// Reset clears the parse state and both valid bits and sets the mark match.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_or_gbk_detector
    import udet_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic byte_present,
    input  wire logic end_of_buffer,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      is_gbk,
    output logic      bom_found
);

    logic  advance;
    logic  word_valid;
    word_t word;

    udet_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .byte_present  (byte_present),
        .end_of_buffer (end_of_buffer),
        .advance       (advance),
        .word_valid    (word_valid),
        .word          (word)
    );

    udet_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_gbk     (is_gbk),
        .bom_found  (bom_found)
    );

endmodule

`default_nettype wire

>>> hdl/udet_in_stage.sv
// ----------------------------------------------------------------------------
// udet_in_stage: input register
// Takes one word per cycle unless the held word waits for the parse stage.
// ----------------------------------------------------------------------------
`default_nettype none

module udet_in_stage
    import udet_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  [7:0] data_byte,
    input  wire logic  byte_present,
    input  wire logic  end_of_buffer,
    input  wire logic  advance,
    output logic       word_valid,
    output word_t      word
);

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;

    // Take a new word when empty or when the held word moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Hold the control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg.data_byte     <= data_byte;
            word_reg.byte_present  <= byte_present;
            word_reg.end_of_buffer <= end_of_buffer;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

>>> hdl/udet_parse.sv
// ----------------------------------------------------------------------------
// udet_parse: parse state and verdict register
// Updates the mark match and sequence state for each word and loads the
// verdict into the result register on the last word of a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module udet_parse
    import udet_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  word_valid,
    input  wire word_t word,
    output logic       advance,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic       is_gbk,
    output logic       bom_found
);

    logic [1:0]  pend_reg, pend_next;
    logic        err_reg, err_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        mark_reg, mark_next;
    logic        out_valid_reg, out_valid_next;
    logic        gbk_reg, gbk_next;
    logic        bom_reg, bom_next;

    logic [1:0]  pend_after;
    logic        err_after;
    logic [1:0]  cnt_after;
    logic        mark_after;
    logic        bom_w;
    logic        bad_w;
    lead_class_t lead;

    // Move on unless a verdict would overwrite one still waiting
    assign advance = word_valid &&
                     (!word.end_of_buffer || !out_valid_reg || out_ready);

    assign lead = class_lead(word.data_byte);

    // Fold the byte into the parse state
    always_comb
    begin
        pend_after = pend_reg;
        err_after  = err_reg;
        cnt_after  = cnt_reg;
        mark_after = mark_reg;
        if (word.byte_present)
        begin
            if (cnt_reg != MARK_LEN)
            begin
                if (word.data_byte != mark_byte(cnt_reg))
                begin
                    mark_after = 1'b0;
                end
                cnt_after = cnt_reg + 2'd1;
            end
            if (pend_reg != 2'd0)
            begin
                if ((word.data_byte & CONT_MASK) != CONT_CODE)
                begin
                    err_after = 1'b1;
                end
                pend_after = pend_reg - 2'd1;
            end
            else if (lead.invalid)
            begin
                err_after = 1'b1;
            end
            else
            begin
                pend_after = lead.cont;
            end
        end
    end

    assign bom_w = (cnt_after == MARK_LEN) && mark_after;
    assign bad_w = err_after || (pend_after != 2'd0);

    // Advance state; clear it after a verdict
    always_comb
    begin
        pend_next      = pend_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        mark_next      = mark_reg;
        gbk_next       = gbk_reg;
        bom_next       = bom_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance)
        begin
            if (word.end_of_buffer)
            begin
                pend_next      = 2'd0;
                err_next       = 1'b0;
                cnt_next       = 2'd0;
                mark_next      = 1'b1;
                gbk_next       = !bom_w && bad_w;
                bom_next       = bom_w;
                out_valid_next = 1'b1;
            end
            else
            begin
                pend_next = pend_after;
                err_next  = err_after;
                cnt_next  = cnt_after;
                mark_next = mark_after;
            end
        end
    end

    // Hold parse state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 2'd0;
            err_reg       <= 1'b0;
            cnt_reg       <= 2'd0;
            mark_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the verdict payload
    always_ff @(posedge clk)
    begin
        gbk_reg <= gbk_next;
        bom_reg <= bom_next;
    end

    assign out_valid = out_valid_reg;
    assign is_gbk    = gbk_reg;
    assign bom_found = bom_reg;

endmodule

`default_nettype wire

>>> hdl/udet_checker.sv
// ----------------------------------------------------------------------------
// udet_checker: port level checks for the detector
// Watches the top level ports for verdict consistency, latency and flow.
// ----------------------------------------------------------------------------
`default_nettype none

module udet_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       end_of_buffer,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       is_gbk,
    input wire logic       bom_found
);

    // A stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({is_gbk, bom_found}))
        else $error("verdict changed while stalled");

    // A found mark always means UTF-8
    a_bom_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_gbk && bom_found))
        else $error("mark found but verdict is GBK");

    // With no verdict waiting, input is never blocked
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result register");

    // A new verdict follows a closing word through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && end_of_buffer, 2))
        else $error("verdict without a closing word");

endmodule

bind utf8_or_gbk_detector udet_checker u_udet_checker (.*);

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for utf8_or_gbk_detector
// Streams buffers of byte words into the detector and predicts each verdict
// with a parse model kept in step with every accepted word, unless a closing
// word types it in. A short table of directed buffers covers the mark, empty
// and truncated cases and bad leads. Random buffers follow: mostly well-formed
// UTF-8, some noise, truncation and corrupted bytes. Both channels idle at
// random, the receiver once holds off long enough to stall the input, and
// the sender drains pending verdicts after the table and once midway.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam logic [7:0] MARK0 = 8'hEF;
    localparam logic [7:0] MARK1 = 8'hBB;
    localparam logic [7:0] MARK2 = 8'hBF;

    localparam int ITEM_TARGET  = 800;
    localparam int GAP_MAX      = 17;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 30;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 8;
    localparam int N_DIRECTED   = 24;

    // One input word, with an optional typed-in verdict for closing words
    typedef struct packed {
        logic [7:0] b;
        logic       p;
        logic       e;
        logic       typed;
        logic       gbk;
        logic       bom;
    } stim_t;

    typedef struct packed {
        logic gbk;
        logic bom;
    } verdict_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_buffer;
    logic       out_valid;
    logic       out_ready;
    logic       is_gbk;
    logic       bom_found;

    // Parse state of the predictor
    logic [1:0] conts_left;
    logic       parse_failed;
    logic [1:0] head_count;
    logic       mark_match;

    verdict_t   verdicts_due[$];
    int         errors;
    int         items_sent;
    int         quiet_cycles;
    logic       send_busy;

    stim_t directed_words [N_DIRECTED] = '{
        // empty buffer
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        // ignored word, then a single ASCII byte
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        // mark alone
        '{8'hEF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBB, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
        // mark followed by an invalid byte: mark still wins
        '{8'hEF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBB, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
        // short buffer cut inside a 3-byte sequence
        '{8'hEF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBB, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // 4-byte sequence closed by an end marker with no byte
        '{8'hF0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h9F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h98, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        // invalid lead
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // bare continuation, error sticks past a good byte
        '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        // 2-byte sequence
        '{8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hA9, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        // low extremes
        '{8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    utf8_or_gbk_detector i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .end_of_buffer(end_of_buffer),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_gbk       (is_gbk),
        .bom_found    (bom_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("tb: mismatch: %s", msg);
    endtask

    task automatic clear_parse();
        conts_left   = 2'd0;
        parse_failed = 1'b0;
        head_count   = 2'd0;
        mark_match   = 1'b1;
    endtask

    // Advance the parse by one accepted word; return the verdict on a closing word
    task automatic parse_word(input logic [7:0] b, input logic p, input logic e,
                              output logic closes, output verdict_t v);
        logic [7:0] want;
        closes = 1'b0;
        v      = '0;
        if (p)
        begin
            if (head_count != 2'd3)
            begin
                case (head_count)
                    2'd0:    want = MARK0;
                    2'd1:    want = MARK1;
                    default: want = MARK2;
                endcase
                if (b != want)
                    mark_match = 1'b0;
                head_count = head_count + 2'd1;
            end
            if (conts_left != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                    parse_failed = 1'b1;
                conts_left = conts_left - 2'd1;
            end
            else if (b[7] == 1'b0)
                conts_left = 2'd0;
            else if (b[7:5] == 3'b110)
                conts_left = 2'd1;
            else if (b[7:4] == 4'b1110)
                conts_left = 2'd2;
            else if (b[7:3] == 5'b11110)
                conts_left = 2'd3;
            else
                parse_failed = 1'b1;
        end
        if (e)
        begin
            closes = 1'b1;
            v.bom  = (head_count == 2'd3) && mark_match;
            v.gbk  = !v.bom && (parse_failed || conts_left != 2'd0);
            clear_parse();
        end
    endtask

    // Offer one word after a random gap, hold it until taken, then predict
    task automatic send_word(input stim_t w);
        int       gap;
        logic     closes;
        verdict_t v;
        if ($urandom_range(0, 15) == 0)
            send_busy = !send_busy;
        gap = send_busy ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= w.b;
        byte_present  <= w.p;
        end_of_buffer <= w.e;
        do @(posedge clk); while (!in_ready);
        parse_word(w.b, w.p, w.e, closes, v);
        if (closes)
        begin
            if (w.typed)
                verdicts_due.push_back(verdict_t'{w.gbk, w.bom});
            else
                verdicts_due.push_back(v);
        end
        if (w.p || w.e)
            items_sent++;
    endtask

    // Drop valid and hold until every pending verdict has come back
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        do @(posedge clk); while (verdicts_due.size() != 0);
    endtask

    // Build one random buffer and stream it in
    task automatic send_random_buffer();
        logic [7:0] bytes_q[$];
        logic [31:0] r;
        int kind;
        int nchars;
        int len;
        int idx;
        stim_t w;
        kind   = $urandom_range(0, 9);
        nchars = $urandom_range(0, 6);
        if (kind == 0)
        begin
            bytes_q.push_back(MARK0);
            bytes_q.push_back(MARK1);
            bytes_q.push_back(MARK2);
        end
        for (int c = 0; c < nchars; c++)
        begin
            r = $urandom();
            if (kind == 7)
                bytes_q.push_back(r[7:0]);
            else
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       bytes_q.push_back({1'b0, r[6:0]});
                    2:       bytes_q.push_back({3'b110, r[4:0]});
                    3:       bytes_q.push_back({4'b1110, r[3:0]});
                    default: bytes_q.push_back({5'b11110, r[2:0]});
                endcase
                for (int k = 1; k < len; k++)
                begin
                    r = $urandom();
                    bytes_q.push_back({2'b10, r[5:0]});
                end
            end
        end
        // cut the tail or spoil one byte
        if (kind == 8 && bytes_q.size() > 0)
            void'(bytes_q.pop_back());
        if (kind == 9 && bytes_q.size() > 0)
        begin
            idx = $urandom_range(0, bytes_q.size() - 1);
            bytes_q[idx] = 8'($urandom_range(0, 255));
        end
        foreach (bytes_q[i])
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                w   = '0;
                w.b = 8'($urandom_range(0, 255));
                send_word(w);
            end
            w   = '0;
            w.b = bytes_q[i];
            w.p = 1'b1;
            w.e = (i == bytes_q.size() - 1) && ($urandom_range(0, 4) != 0);
            send_word(w);
            if (w.e)
                return;
        end
        // close with an end marker that carries no byte
        w   = '0;
        w.b = 8'($urandom_range(0, 255));
        w.e = 1'b1;
        send_word(w);
    endtask

    // Sender
    initial
    begin
        logic mid_drained;
        in_valid      <= 1'b0;
        data_byte     <= 8'h00;
        byte_present  <= 1'b0;
        end_of_buffer <= 1'b0;
        rst_n         <= 1'b0;
        errors      = 0;
        items_sent  = 0;
        send_busy   = 1'b1;
        mid_drained = 1'b0;
        clear_parse();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_words[i])
            send_word(directed_words[i]);
        drain_verdicts();
        while (items_sent < ITEM_TARGET)
        begin
            send_random_buffer();
            // pause once midway until every verdict is back
            if (!mid_drained && items_sent >= ITEM_TARGET / 2)
            begin
                drain_verdicts();
                mid_drained = 1'b1;
            end
        end
        drain_verdicts();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: random stalls per verdict, one long hold-off
    initial
    begin
        int stall;
        int taken;
        logic busy;
        out_ready <= 1'b0;
        taken = 0;
        busy  = 1'b1;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                busy = !busy;
            stall = busy ? $urandom_range(0, GAP_MAX) : 0;
            if (taken == HOLD_AT)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && out_valid));
            taken++;
        end
    end

    // Check each verdict against the oldest one due
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("verdict with none due");
            else
            begin
                v = verdicts_due.pop_front();
                if (is_gbk !== v.gbk)
                    report_mismatch($sformatf("is_gbk got %b want %b", is_gbk, v.gbk));
                if (bom_found !== v.bom)
                    report_mismatch($sformatf("bom_found got %b want %b", bom_found, v.bom));
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

`default_nettype wire
